// ----- rtl/core/stunmp_pkg.sv -----
`default_nettype none
package stunmp_pkg;

  localparam int unsigned MAX_RES   = 3;
  localparam int unsigned RES_DEPTH = 6;
  localparam int unsigned RES_CNT_W = $clog2(RES_DEPTH + 1);
  localparam int unsigned RES_IDX_W = $clog2(RES_DEPTH);
  localparam int unsigned STEP_CNT_W = $clog2(MAX_RES + 1);

  // result kinds
  localparam logic [2:0] KIND_TID      = 3'd0;
  localparam logic [2:0] KIND_HEADER   = 3'd1;
  localparam logic [2:0] KIND_VALUE    = 3'd2;
  localparam logic [2:0] KIND_ATTR_END = 3'd3;
  localparam logic [2:0] KIND_MSG_END  = 3'd4;

  // message end status
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_SHORT     = 3'd1;
  localparam logic [2:0] ST_BAD_BITS  = 3'd2;
  localparam logic [2:0] ST_BAD_COOKIE = 3'd3;
  localparam logic [2:0] ST_TRAILING  = 3'd4;

  localparam logic [7:0]  LEAD_BITS_MASK = 8'hC0;
  localparam logic [15:0] POS_MAX        = 16'hFFFF;
  localparam logic [15:0] POS_HDR_LAST   = 16'd19;
  localparam logic [15:0] POS_COOKIE_LO  = 16'd4;
  localparam logic [15:0] POS_COOKIE_HI  = 16'd7;
  localparam logic [15:0] POS_TID_LO     = 16'd8;
  localparam logic [15:0] ATTR_HDR_BYTES = 16'd4;

  localparam logic [7:0] COOKIE [4] = '{8'h21, 8'h12, 8'hA4, 8'h42};

  typedef enum logic [1:0] {
    FAULT_NONE   = 2'd0,
    FAULT_BITS   = 2'd1,
    FAULT_COOKIE = 2'd2
  } fault_t;

  typedef enum logic [2:0] {
    PH_HEADER     = 3'd0,
    PH_ATTR_HEAD  = 3'd1,
    PH_ATTR_VALUE = 3'd2,
    PH_ATTR_PAD   = 3'd3,
    PH_SKIP       = 3'd4
  } phase_t;

  typedef struct packed {
    logic [15:0] byte_position;
    logic [7:0]  first_type_byte;
    fault_t      header_fault;
    phase_t      phase;
    logic [15:0] attr_type;
    logic [15:0] attr_length;
    logic [15:0] attr_bytes_seen;
    logic [1:0]  pad_remaining;
  } parse_state_t;

  localparam parse_state_t STATE_RESET = '{
    byte_position:   16'd0,
    first_type_byte: 8'd0,
    header_fault:    FAULT_NONE,
    phase:           PH_HEADER,
    attr_type:       16'd0,
    attr_length:     16'd0,
    attr_bytes_seen: 16'd0,
    pad_remaining:   2'd0
  };

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  payload_byte;
    logic [11:0] method;
    logic [1:0]  msg_class;
    logic [15:0] attr_type;
    logic [15:0] attr_length;
    logic [15:0] value_offset;
    logic [2:0]  status;
    logic        last_result;
  } result_t;

  localparam result_t RESULT_ZERO = '0;

endpackage
`default_nettype wire

// ----- rtl/core/stunmp_if.sv -----
`default_nettype none
interface stunmp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface stunmp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [7:0]  payload_byte;
  logic [11:0] method;
  logic [1:0]  msg_class;
  logic [15:0] attr_type;
  logic [15:0] attr_length;
  logic [15:0] value_offset;
  logic [2:0]  status;
  logic        last_result;

  modport source (
    output valid, output kind, output payload_byte, output method, output msg_class,
    output attr_type, output attr_length, output value_offset, output status,
    output last_result, input ready
  );
  modport sink (
    input valid, input kind, input payload_byte, input method, input msg_class,
    input attr_type, input attr_length, input value_offset, input status,
    input last_result, output ready
  );
endinterface
`default_nettype wire

// ----- rtl/core/stun_message_parser.sv -----
`default_nettype none
// STUN message parser: one datagram byte per request on in_bus (data_byte,
// last_byte set on the final byte). Records leave on out_bus: header
// (method, class), transaction id bytes, attribute value bytes with their
// offset, an attribute-complete record per whole attribute, and a
// message-end record with the status on the last byte.
// A taken byte's records are registered into a six-entry result queue, whose
// head out_bus presents. A byte yields zero to three records, and out_bus drains
// one record per cycle from that queue while the receiver takes them, so the
// sustained rate is one byte per cycle while bytes yield at most one record each
// and otherwise is bounded by the record count.
// in_bus.ready stays high while the queue has room for three more records,
// so input keeps flowing while results wait; when the receiver stalls, the
// queue fills and ready drops until records are taken.
// rst_n (synchronous, active low) empties the queue and returns the parser
// to the start of a datagram. After the last byte the parser is at the start
// of the next datagram without a gap.
module stun_message_parser (
  input  wire logic     clk,
  input  wire logic     rst_n,
  stunmp_in_if.sink     in_bus,
  stunmp_out_if.source  out_bus
);
  import stunmp_pkg::*;

  parse_state_t              state_r;
  parse_state_t              state_nxt;
  result_t [MAX_RES-1:0]     res;
  logic [STEP_CNT_W-1:0]     res_cnt;
  logic                      room;
  logic                      accept;

  assign in_bus.ready = room;
  assign accept       = in_bus.valid && room;

  stunmp_step u_step (
    .data_byte (in_bus.data_byte),
    .last_byte (in_bus.last_byte),
    .state     (state_r),
    .state_nxt (state_nxt),
    .res       (res),
    .res_cnt   (res_cnt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= STATE_RESET;
    end else if (accept) begin
      state_r <= state_nxt;
    end
  end

  stunmp_res_buf u_res_buf (
    .clk     (clk),
    .rst_n   (rst_n),
    .load    (accept),
    .res     (res),
    .res_cnt (res_cnt),
    .room    (room),
    .out_bus (out_bus)
  );

endmodule
`default_nettype wire

// ----- rtl/core/stunmp_step.sv -----
`default_nettype none
module stunmp_step (
  input  wire logic [7:0]                              data_byte,
  input  wire logic                                    last_byte,
  input  wire stunmp_pkg::parse_state_t                state,
  output stunmp_pkg::parse_state_t                     state_nxt,
  output stunmp_pkg::result_t [stunmp_pkg::MAX_RES-1:0] res,
  output logic [stunmp_pkg::STEP_CNT_W-1:0]            res_cnt
);
  import stunmp_pkg::*;

  parse_state_t            s;
  result_t                 a0;
  result_t                 a1;
  result_t                 fin;
  logic [1:0]              na;
  logic [15:0]             pos;
  logic [15:0]             tword;
  logic [16:0]             seen_inc;
  logic [2:0]              st;
  logic [STEP_CNT_W-1:0]   cnt;

  always_comb begin
    s        = state;
    a0       = RESULT_ZERO;
    a1       = RESULT_ZERO;
    fin      = RESULT_ZERO;
    na       = 2'd0;
    pos      = state.byte_position;
    tword    = {state.first_type_byte, data_byte};
    seen_inc = {1'b0, state.attr_bytes_seen} + 17'd1;
    st       = ST_OK;

    unique case (state.phase)
      PH_HEADER: begin
        if (pos == 16'd0) begin
          s.first_type_byte = data_byte;
          if ((data_byte & LEAD_BITS_MASK) != 8'd0) s.header_fault = FAULT_BITS;
        end else if (pos == 16'd1) begin
          if (state.header_fault == FAULT_NONE) begin
            a0.kind      = KIND_HEADER;
            a0.method    = {tword[13:9], tword[7:5], tword[3:0]};
            a0.msg_class = {state.first_type_byte[0], data_byte[4]};
            na           = 2'd1;
          end
        end else if (pos >= POS_COOKIE_LO && pos <= POS_COOKIE_HI) begin
          if (state.header_fault == FAULT_NONE && data_byte != COOKIE[pos[1:0]])
            s.header_fault = FAULT_COOKIE;
        end else if (pos >= POS_TID_LO && pos <= POS_HDR_LAST) begin
          if (state.header_fault == FAULT_NONE) begin
            a0.kind         = KIND_TID;
            a0.payload_byte = data_byte;
            na              = 2'd1;
          end
        end
        if (pos == POS_HDR_LAST) begin
          s.phase           = (s.header_fault != FAULT_NONE) ? PH_SKIP : PH_ATTR_HEAD;
          s.attr_bytes_seen = 16'd0;
        end
      end
      PH_ATTR_HEAD: begin
        unique case (state.attr_bytes_seen[1:0])
          2'd0:    s.attr_type   = {data_byte, 8'd0};
          2'd1:    s.attr_type   = {state.attr_type[15:8], data_byte};
          2'd2:    s.attr_length = {data_byte, 8'd0};
          default: s.attr_length = {state.attr_length[15:8], data_byte};
        endcase
        s.attr_bytes_seen = seen_inc[15:0];
        if (seen_inc >= {1'b0, ATTR_HDR_BYTES}) begin
          s.attr_bytes_seen = 16'd0;
          if (s.attr_length == 16'd0) begin
            a0.kind        = KIND_ATTR_END;
            a0.attr_type   = s.attr_type;
            a0.attr_length = s.attr_length;
            na             = 2'd1;
            s.pad_remaining = 2'd0;
          end else begin
            s.phase = PH_ATTR_VALUE;
          end
        end
      end
      PH_ATTR_VALUE: begin
        a0.kind         = KIND_VALUE;
        a0.payload_byte = data_byte;
        a0.attr_type    = state.attr_type;
        a0.attr_length  = state.attr_length;
        a0.value_offset = state.attr_bytes_seen;
        na              = 2'd1;
        s.attr_bytes_seen = seen_inc[15:0];
        if (seen_inc >= {1'b0, state.attr_length}) begin
          a1.kind         = KIND_ATTR_END;
          a1.attr_type    = state.attr_type;
          a1.attr_length  = state.attr_length;
          na              = 2'd2;
          s.attr_bytes_seen = 16'd0;
          s.pad_remaining   = 2'd0 - state.attr_length[1:0];
          s.phase = (s.pad_remaining != 2'd0) ? PH_ATTR_PAD : PH_ATTR_HEAD;
        end
      end
      PH_ATTR_PAD: begin
        if (state.pad_remaining != 2'd0) s.pad_remaining = state.pad_remaining - 2'd1;
        if (s.pad_remaining == 2'd0) s.phase = PH_ATTR_HEAD;
      end
      default: begin
      end
    endcase

    if (pos != POS_MAX) s.byte_position = pos + 16'd1;

    cnt = STEP_CNT_W'(na);
    if (last_byte) begin
      priority if (pos < POS_HDR_LAST)          st = ST_SHORT;
      else if (s.header_fault == FAULT_BITS)    st = ST_BAD_BITS;
      else if (s.header_fault != FAULT_NONE)    st = ST_BAD_COOKIE;
      else if (s.phase == PH_ATTR_VALUE ||
               (s.phase == PH_ATTR_HEAD && s.attr_bytes_seen != 16'd0))
                                                st = ST_TRAILING;
      else                                      st = ST_OK;
      fin.kind   = KIND_MSG_END;
      fin.status = st;
      cnt        = STEP_CNT_W'(na) + STEP_CNT_W'(1);
      s          = STATE_RESET;
    end
  end

  // pack the phase records, then the end record, and flag the final one
  always_comb begin
    res[0] = a0;
    res[1] = a1;
    res[2] = RESULT_ZERO;
    unique case (na)
      2'd0:    res[0] = fin;
      2'd1:    res[1] = fin;
      default: res[2] = fin;
    endcase
    if (cnt != '0) res[cnt - STEP_CNT_W'(1)].last_result = 1'b1;
  end

  assign state_nxt = s;
  assign res_cnt   = cnt;

endmodule
`default_nettype wire

// ----- rtl/core/stunmp_res_buf.sv -----
`default_nettype none
module stunmp_res_buf (
  input  wire logic                                    clk,
  input  wire logic                                    rst_n,
  input  wire logic                                    load,
  input  wire stunmp_pkg::result_t [stunmp_pkg::MAX_RES-1:0] res,
  input  wire logic [stunmp_pkg::STEP_CNT_W-1:0]       res_cnt,
  output logic                                         room,
  stunmp_out_if.source                                 out_bus
);
  import stunmp_pkg::*;

  result_t [RES_DEPTH-1:0] buf_r;
  result_t [RES_DEPTH-1:0] buf_nxt;
  logic [RES_CNT_W-1:0]    cnt_r;
  logic [RES_CNT_W-1:0]    cnt_nxt;
  logic [RES_CNT_W-1:0]    base;
  logic [RES_CNT_W-1:0]    k;
  logic                    pop;

  assign pop  = out_bus.valid && out_bus.ready;
  assign room = (cnt_r <= RES_CNT_W'(RES_DEPTH - MAX_RES));
  assign base = cnt_r - RES_CNT_W'(pop);

  always_comb begin
    buf_nxt = buf_r;
    k       = '0;
    // shift out the taken head
    if (pop) begin
      for (int j = 0; j < RES_DEPTH - 1; j++) buf_nxt[j] = buf_r[j + 1];
    end
    // append new records behind what stays
    if (load) begin
      for (int j = 0; j < RES_DEPTH; j++) begin
        k = RES_CNT_W'(j) - base;
        if (RES_CNT_W'(j) >= base && k < RES_CNT_W'(res_cnt))
          buf_nxt[j] = res[k[STEP_CNT_W-1:0]];
      end
    end
    cnt_nxt = base + (load ? RES_CNT_W'(res_cnt) : RES_CNT_W'(0));
  end

  always_ff @(posedge clk) begin
    buf_r <= buf_nxt;
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  assign out_bus.valid        = (cnt_r != '0);
  assign out_bus.kind         = buf_r[0].kind;
  assign out_bus.payload_byte = buf_r[0].payload_byte;
  assign out_bus.method       = buf_r[0].method;
  assign out_bus.msg_class    = buf_r[0].msg_class;
  assign out_bus.attr_type    = buf_r[0].attr_type;
  assign out_bus.attr_length  = buf_r[0].attr_length;
  assign out_bus.value_offset = buf_r[0].value_offset;
  assign out_bus.status       = buf_r[0].status;
  assign out_bus.last_result  = buf_r[0].last_result;

endmodule
`default_nettype wire

// ----- dv/stun_message_parser_test.sv -----
import stunmp_pkg::*;

class stun_record_board;
  result_t expected_records[$];
  result_t step_records[$];
  int unsigned failures;

  logic [15:0] position;
  logic [7:0]  type_hi;
  fault_t      fault;
  phase_t      phase;
  logic [15:0] attr_type;
  logic [15:0] attr_len;
  logic [15:0] seen;
  logic [1:0]  pad;

  function new();
    failures = 0;
    restart();
  endfunction

  function void restart();
    position  = '0;
    type_hi   = '0;
    fault     = FAULT_NONE;
    phase     = PH_HEADER;
    attr_type = '0;
    attr_len  = '0;
    seen      = '0;
    pad       = '0;
  endfunction

  function void add_record(logic [2:0] kind, logic [7:0] payload, logic [11:0] meth,
                           logic [1:0] cls, logic [2:0] st, logic [15:0] offset);
    result_t rec;
    bit      per_attr;
    per_attr = (kind == KIND_VALUE) || (kind == KIND_ATTR_END);
    rec = RESULT_ZERO;
    rec.kind         = kind;
    rec.payload_byte = payload;
    rec.method       = meth;
    rec.msg_class    = cls;
    rec.attr_type    = per_attr ? attr_type : 16'd0;
    rec.attr_length  = per_attr ? attr_len : 16'd0;
    rec.value_offset = offset;
    rec.status       = st;
    step_records = {step_records, rec};
  endfunction

  // Advance the parser copy by one accepted byte and queue its records.
  function void note_byte(logic [7:0] b, logic last);
    logic [15:0] at;
    logic [15:0] tw;
    logic [2:0]  st;
    at = position;
    step_records.delete();
    case (phase)
      PH_HEADER: begin
        if (at == 16'd0) begin
          type_hi = b;
          if ((b & LEAD_BITS_MASK) != 8'd0) fault = FAULT_BITS;
        end else if (at == 16'd1) begin
          if (fault == FAULT_NONE) begin
            tw = {type_hi, b};
            add_record(KIND_HEADER, 8'd0, {tw[13:9], tw[7:5], tw[3:0]},
                       {type_hi[0], b[4]}, ST_OK, 16'd0);
          end
        end else if (at >= POS_COOKIE_LO && at <= POS_COOKIE_HI) begin
          if (fault == FAULT_NONE && b != COOKIE[at[1:0]]) fault = FAULT_COOKIE;
        end else if (at >= POS_TID_LO && at <= POS_HDR_LAST) begin
          if (fault == FAULT_NONE) add_record(KIND_TID, b, 12'd0, 2'd0, ST_OK, 16'd0);
        end
        if (at == POS_HDR_LAST) begin
          phase = (fault != FAULT_NONE) ? PH_SKIP : PH_ATTR_HEAD;
          seen  = '0;
        end
      end
      PH_ATTR_HEAD: begin
        case (seen[1:0])
          2'd0: attr_type = {b, 8'h00};
          2'd1: attr_type[7:0] = b;
          2'd2: attr_len = {b, 8'h00};
          default: attr_len[7:0] = b;
        endcase
        seen++;
        if (seen >= ATTR_HDR_BYTES) begin
          seen = '0;
          if (attr_len == 16'd0) begin
            add_record(KIND_ATTR_END, 8'd0, 12'd0, 2'd0, ST_OK, 16'd0);
            pad = '0;
          end else begin
            phase = PH_ATTR_VALUE;
          end
        end
      end
      PH_ATTR_VALUE: begin
        add_record(KIND_VALUE, b, 12'd0, 2'd0, ST_OK, seen);
        seen++;
        if (seen >= attr_len) begin
          add_record(KIND_ATTR_END, 8'd0, 12'd0, 2'd0, ST_OK, 16'd0);
          seen  = '0;
          pad   = 2'd0 - attr_len[1:0];
          phase = (pad != 2'd0) ? PH_ATTR_PAD : PH_ATTR_HEAD;
        end
      end
      PH_ATTR_PAD: begin
        if (pad != 2'd0) pad--;
        if (pad == 2'd0) phase = PH_ATTR_HEAD;
      end
      default: ;
    endcase

    if (position != POS_MAX) position++;

    if (last) begin
      if (at < POS_HDR_LAST) st = ST_SHORT;
      else if (fault == FAULT_BITS) st = ST_BAD_BITS;
      else if (fault != FAULT_NONE) st = ST_BAD_COOKIE;
      else if (phase == PH_ATTR_VALUE || (phase == PH_ATTR_HEAD && seen != 16'd0))
        st = ST_TRAILING;
      else st = ST_OK;
      add_record(KIND_MSG_END, 8'd0, 12'd0, 2'd0, st, 16'd0);
      restart();
    end

    if (step_records.size() > 0) step_records[step_records.size() - 1].last_result = 1'b1;
    expected_records = {expected_records, step_records};
  endfunction

  function void compare(string field, logic [15:0] want, logic [15:0] actual);
    if (actual !== want) begin
      $error("%s: expected %0h, got %0h", field, want, actual);
      failures++;
    end
  endfunction

  function void check_record(result_t got);
    result_t want;
    if (expected_records.size() == 0) begin
      $error("record: none expected, got kind %0d", got.kind);
      failures++;
      return;
    end
    want = expected_records.pop_front();
    compare("kind", want.kind, got.kind);
    compare("payload_byte", want.payload_byte, got.payload_byte);
    compare("method", want.method, got.method);
    compare("msg_class", want.msg_class, got.msg_class);
    compare("attr_type", want.attr_type, got.attr_type);
    compare("attr_length", want.attr_length, got.attr_length);
    compare("value_offset", want.value_offset, got.value_offset);
    compare("status", want.status, got.status);
    compare("last_result", want.last_result, got.last_result);
  endfunction
endclass

module stun_message_parser_test;
  logic clk = 1'b0;
  logic rst_n;

  stunmp_in_if  in_bus();
  stunmp_out_if out_bus();

  stun_message_parser dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus)
  );

  stun_record_board board = new();

  logic [7:0] dgram[$];
  int in_calm    = 0;
  int out_calm   = 0;
  int sent_bytes = 0;
  result_t seen_record;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Mostly random waits, with stretches of back-to-back traffic.
  function automatic int draw_wait(ref int calm_left);
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) calm_left = $urandom_range(10, 60);
    return $urandom_range(0, 19);
  endfunction

  function automatic void add_byte(input logic [7:0] b);
    dgram = {dgram, b};
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic l);
    int gap;
    gap = draw_wait(in_calm);
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid     <= 1'b1;
    in_bus.data_byte <= b;
    in_bus.last_byte <= l;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    board.note_byte(b, l);
    sent_bytes++;
  endtask

  task automatic send_datagram();
    for (int i = 0; i < dgram.size(); i++) send_byte(dgram[i], i == dgram.size() - 1);
    dgram.delete();
  endtask

  task automatic put_header(input logic [15:0] type_word, input bit cookie_good);
    add_byte(type_word[15:8]);
    add_byte(type_word[7:0]);
    repeat (2) add_byte(8'($urandom));
    for (int k = 0; k < 4; k++) add_byte(COOKIE[k]);
    if (!cookie_good) dgram[4 + $urandom_range(0, 3)] ^= 8'($urandom_range(1, 255));
    repeat (12) add_byte(8'($urandom));
  endtask

  task automatic put_attr(input logic [15:0] atype, input logic [15:0] alen);
    add_byte(atype[15:8]);
    add_byte(atype[7:0]);
    add_byte(alen[15:8]);
    add_byte(alen[7:0]);
    repeat (alen) add_byte(8'($urandom));
    repeat ((4 - alen % 4) % 4) add_byte(8'($urandom));
  endtask

  always @(posedge clk) begin
    if (rst_n && out_bus.valid && out_bus.ready) begin
      seen_record.kind         = out_bus.kind;
      seen_record.payload_byte = out_bus.payload_byte;
      seen_record.method       = out_bus.method;
      seen_record.msg_class    = out_bus.msg_class;
      seen_record.attr_type    = out_bus.attr_type;
      seen_record.attr_length  = out_bus.attr_length;
      seen_record.value_offset = out_bus.value_offset;
      seen_record.status       = out_bus.status;
      seen_record.last_result  = out_bus.last_result;
      board.check_record(seen_record);
    end
  end

  initial begin
    int stall;
    out_bus.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = draw_wait(out_calm);
      if (stall > 0) begin
        out_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_bus.ready <= 1'b1;
      @(posedge clk);
      while (!out_bus.valid) @(posedge clk);
    end
  end

  initial begin
    #4000000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    bit bad_bits;
    bit bad_cookie;
    logic [15:0] type_word;

    rst_n            <= 1'b0;
    in_bus.valid     <= 1'b0;
    in_bus.data_byte <= 8'd0;
    in_bus.last_byte <= 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // lone byte with both leading bits set: too short wins over the fault
    add_byte(8'hFF);
    send_datagram();
    // header one byte short
    put_header(16'h0001, 1'b1);
    void'(dgram.pop_back());
    send_datagram();
    // all-ones method and class, zero-length attribute ends on the last byte
    put_header(16'h3FFF, 1'b1);
    put_attr(16'h0000, 16'd0);
    send_datagram();
    // padded and unpadded values, datagram ends inside padding
    put_header(16'h0000, 1'b1);
    put_attr(16'h8022, 16'd1);
    put_attr(16'h0001, 16'd4);
    put_attr(16'h0020, 16'd5);
    void'(dgram.pop_back());
    void'(dgram.pop_back());
    send_datagram();
    // bad cookie: header record still comes, then nothing but the end
    put_header(16'h0101, 1'b1);
    dgram[7] = 8'h00;
    put_attr(16'h0006, 16'd3);
    send_datagram();
    // bad leading bits found before bad cookie
    put_header(16'h8001, 1'b0);
    put_attr(16'h0006, 16'd2);
    send_datagram();
    put_header(16'h4001, 1'b1);
    add_byte(8'h00);
    send_datagram();
    // value cut short
    put_header(16'h0111, 1'b1);
    put_attr(16'h0006, 16'd8);
    repeat (3) void'(dgram.pop_back());
    send_datagram();
    // partial attribute header
    put_header(16'h0002, 1'b1);
    add_byte(8'h80);
    add_byte(8'h28);
    send_datagram();

    while (sent_bytes < 220) begin
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 30)) add_byte(8'($urandom));
      end else begin
        bad_bits   = ($urandom_range(0, 9) == 0);
        bad_cookie = ($urandom_range(0, 9) == 0);
        type_word  = {2'b00, 14'($urandom)};
        if (bad_bits) type_word[15:14] = 2'($urandom_range(1, 3));
        put_header(type_word, !bad_cookie);
        repeat ($urandom_range(0, 3)) put_attr(16'($urandom), 16'($urandom_range(0, 10)));
        if ($urandom_range(0, 5) == 0) repeat ($urandom_range(1, 3)) add_byte(8'($urandom));
        if ($urandom_range(0, 4) == 0)
          repeat ($urandom_range(1, 6)) if (dgram.size() > 1) void'(dgram.pop_back());
      end
      send_datagram();
    end

    in_bus.valid <= 1'b0;
    while (board.expected_records.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (board.failures == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end
endmodule
